// File: hdl/four_port_auto_increment_ram_window_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the auto-increment RAM window
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FOUR_PORT_AUTO_INCREMENT_RAM_WINDOW_DEFINES_SVH
`define FOUR_PORT_AUTO_INCREMENT_RAM_WINDOW_DEFINES_SVH

`ifndef SYNTH
`define AWIN_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AWIN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AWIN_ASSERT_SAME(label, ante, cons)
`define AWIN_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/awin_pkg.sv
// ----------------------------------------------------------------------------
// awin_pkg
// Types and constants shared by the auto-increment RAM window.
// ----------------------------------------------------------------------------
package awin_pkg;

  localparam int PORT_COUNT = 4;
  localparam int PORT_IDX_W = $clog2(PORT_COUNT);

  // port register index
  localparam logic [3:0] REG_DATA0  = 4'h0;
  localparam logic [3:0] REG_DATA1  = 4'h1;
  localparam logic [3:0] REG_BASE0  = 4'h2;
  localparam logic [3:0] REG_BASE1  = 4'h3;
  localparam logic [3:0] REG_BASE2  = 4'h4;
  localparam logic [3:0] REG_OFF_LO = 4'h5;
  localparam logic [3:0] REG_OFF_HI = 4'h6;
  localparam logic [3:0] REG_INC_LO = 4'h7;
  localparam logic [3:0] REG_INC_HI = 4'h8;
  localparam logic [3:0] REG_CTRL   = 4'h9;
  localparam logic [3:0] REG_TRIG   = 4'hA;

  // offset-to-base trigger codes
  localparam logic [1:0] TRIG_OFF_LO = 2'd1;
  localparam logic [1:0] TRIG_OFF_HI = 2'd2;
  localparam logic [1:0] TRIG_REG    = 2'd3;

  // control bits
  localparam int CTL_AUTO_INC = 0;
  localparam int CTL_ADD_OFF  = 1;
  localparam int CTL_BIAS     = 3;
  localparam int CTL_INC_BASE = 4;

  // register page addresses (low 13 bits)
  localparam logic [12:0] PG_VAL0  = 13'h1AE0;
  localparam logic [12:0] PG_VAL1  = 13'h1AE1;
  localparam logic [12:0] PG_VAL2  = 13'h1AE2;
  localparam logic [12:0] PG_VAL3  = 13'h1AE3;
  localparam logic [12:0] PG_SHIFT = 13'h1AE4;
  localparam logic [12:0] PG_ROT   = 13'h1AE5;
  localparam logic [12:0] PG_VER   = 13'h1AFE;
  localparam logic [12:0] PG_SIG   = 13'h1AFF;

  localparam logic [7:0]  BANK_PAGE   = 8'hFF;
  localparam logic [5:0]  BANK_DPORT  = 6'h10;
  localparam logic [3:0]  PAGE_HI     = 4'hD;
  localparam logic [5:0]  REGWIN_HI   = 6'h34;
  localparam logic [23:0] OFFSET_BIAS = 24'hFF0000;
  localparam logic [7:0]  VER_BYTE    = 8'h10;
  localparam logic [7:0]  SIG_BYTE    = 8'h51;
  localparam logic [7:0]  UNKNOWN_REG = 8'hFF;

  typedef struct packed {
    logic        en;
    logic        we;
    logic [23:0] addr;
    logic [7:0]  wdata;
  } awin_ram_req_t;

endpackage

// File: hdl/awin_in_if.sv
// ----------------------------------------------------------------------------
// awin_in_if
// Bus access channel: valid/ready with func, bank, address and data.
// ----------------------------------------------------------------------------
interface awin_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  bank;
  logic [15:0] address;
  logic [7:0]  data_in;

  modport source (output valid, func, bank, address, data_in, input ready);
  modport sink (input valid, func, bank, address, data_in, output ready);
endinterface

// File: hdl/awin_out_if.sv
// ----------------------------------------------------------------------------
// awin_out_if
// Result channel: valid/ready with one read byte.
// ----------------------------------------------------------------------------
interface awin_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// File: hdl/awin_ram.sv
// ----------------------------------------------------------------------------
// awin_ram
// Single-port byte RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module awin_ram
  import awin_pkg::*;
#(
  parameter int RAM_BYTES = 2097152
) (
  input  logic          clk,
  input  awin_ram_req_t req,
  output logic [7:0]    rdata
);

  localparam int AW = $clog2(RAM_BYTES);

  logic [7:0] mem [RAM_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr[AW-1:0]] <= req.wdata;
      end else begin
        rdata_r <= mem[req.addr[AW-1:0]];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/awin_regs.sv
// ----------------------------------------------------------------------------
// awin_regs
// Access decode, port registers, value register and RAM request build.
// ----------------------------------------------------------------------------
module awin_regs
  import awin_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic          func,
  input  logic [7:0]    bank,
  input  logic [15:0]   address,
  input  logic [7:0]    data_in,
  output awin_ram_req_t req,
  output logic          sel_ram,
  output logic [7:0]    imm_byte
);

  logic [23:0] base_r [PORT_COUNT];
  logic [23:0] base_nxt [PORT_COUNT];
  logic [15:0] off_r [PORT_COUNT];
  logic [15:0] off_nxt [PORT_COUNT];
  logic [15:0] inc_r [PORT_COUNT];
  logic [15:0] inc_nxt [PORT_COUNT];
  logic [6:0]  ctl_r [PORT_COUNT];
  logic [6:0]  ctl_nxt [PORT_COUNT];
  logic [31:0] val_r, val_nxt;
  logic [7:0]  shcmd_r, shcmd_nxt;
  logic [7:0]  rotcmd_r, rotcmd_nxt;

  logic [12:0] a13;
  logic        is_page, in_window, in_regs, is_dport, data_acc, reg_wr;
  logic [PORT_IDX_W-1:0] p;
  logic [3:0]  r;
  logic [23:0] b, sum;
  logic [15:0] o, inc, off_w;
  logic [6:0]  c;
  logic [3:0]  rn;
  logic [2:0]  ln;
  logic [63:0] dbl;
  logic [63:0] rot_r64, rot_l64;
  logic [7:0]  rd_byte;

  always_comb begin
    a13       = address[12:0];
    is_page   = (bank == BANK_PAGE);
    in_window = is_page && (a13[12:9] == PAGE_HI);
    in_regs   = in_window && (a13[12:7] == REGWIN_HI);
    is_dport  = (bank[7:2] == BANK_DPORT);
    p         = is_dport ? bank[PORT_IDX_W-1:0] : a13[4 +: PORT_IDX_W];
    r         = a13[3:0];
    data_acc  = is_dport || (in_regs && (r == REG_DATA0 || r == REG_DATA1));
    reg_wr    = acc && in_regs && func;

    b   = base_r[p];
    o   = off_r[p];
    inc = inc_r[p];
    c   = ctl_r[p];

    off_w = o;
    if (in_regs && func && r == REG_OFF_LO) begin
      off_w = {o[15:8], data_in};
    end else if (in_regs && func && r == REG_OFF_HI) begin
      off_w = {data_in, o[7:0]};
    end
    sum = b + {8'h00, off_w} + (c[CTL_BIAS] ? OFFSET_BIAS : 24'h000000);

    req.en    = acc && data_acc;
    req.we    = func;
    req.addr  = c[CTL_ADD_OFF] ? sum : b;
    req.wdata = data_in;

    base_nxt   = base_r;
    off_nxt    = off_r;
    inc_nxt    = inc_r;
    ctl_nxt    = ctl_r;
    val_nxt    = val_r;
    shcmd_nxt  = shcmd_r;
    rotcmd_nxt = rotcmd_r;

    if (acc && data_acc && c[CTL_AUTO_INC]) begin
      if (c[CTL_INC_BASE]) begin
        base_nxt[p] = b + {8'h00, inc};
      end else begin
        off_nxt[p] = o + inc;
      end
    end

    if (reg_wr) begin
      unique case (r)
        REG_BASE0: base_nxt[p] = {b[23:8], data_in};
        REG_BASE1: base_nxt[p] = {b[23:16], data_in, b[7:0]};
        REG_BASE2: base_nxt[p] = {data_in, b[15:0]};
        REG_OFF_LO: begin
          off_nxt[p] = off_w;
          if (c[6:5] == TRIG_OFF_LO) begin
            base_nxt[p] = sum;
          end
        end
        REG_OFF_HI: begin
          off_nxt[p] = off_w;
          if (c[6:5] == TRIG_OFF_HI) begin
            base_nxt[p] = sum;
          end
        end
        REG_INC_LO: inc_nxt[p] = {inc[15:8], data_in};
        REG_INC_HI: inc_nxt[p] = {data_in, inc[7:0]};
        REG_CTRL:   ctl_nxt[p] = data_in[6:0];
        REG_TRIG: begin
          if (c[6:5] == TRIG_REG) begin
            base_nxt[p] = sum;
          end
        end
        default: ;
      endcase
    end

    // shift and rotate amounts
    rn      = {1'b0, ~data_in[2:0]} + 4'd1;
    ln      = data_in[2:0];
    dbl     = {val_r, val_r};
    rot_r64 = dbl >> rn;
    rot_l64 = dbl << ln;

    if (acc && in_window && !in_regs && func) begin
      unique case (a13)
        PG_VAL0: val_nxt = {val_r[31:8], data_in};
        PG_VAL1: val_nxt = {val_r[31:16], data_in, val_r[7:0]};
        PG_VAL2: val_nxt = {val_r[31:24], data_in, val_r[15:0]};
        PG_VAL3: val_nxt = {data_in, val_r[23:0]};
        PG_SHIFT: begin
          shcmd_nxt = data_in;
          if (data_in != 8'h00) begin
            val_nxt = data_in[3] ? (val_r >> rn) : (val_r << ln);
          end
        end
        PG_ROT: begin
          rotcmd_nxt = data_in;
          if (data_in != 8'h00) begin
            val_nxt = data_in[3] ? rot_r64[31:0] : rot_l64[63:32];
          end
        end
        default: ;
      endcase
    end

    rd_byte = data_in;
    if (in_regs) begin
      unique case (r)
        REG_DATA0, REG_DATA1: rd_byte = 8'h00;
        REG_BASE0:  rd_byte = b[7:0];
        REG_BASE1:  rd_byte = b[15:8];
        REG_BASE2:  rd_byte = b[23:16];
        REG_OFF_LO: rd_byte = o[7:0];
        REG_OFF_HI: rd_byte = o[15:8];
        REG_INC_LO: rd_byte = inc[7:0];
        REG_INC_HI: rd_byte = inc[15:8];
        REG_CTRL:   rd_byte = {1'b0, c};
        REG_TRIG:   rd_byte = 8'h00;
        default:    rd_byte = UNKNOWN_REG;
      endcase
    end else if (in_window) begin
      unique case (a13)
        PG_VAL0:  rd_byte = val_r[7:0];
        PG_VAL1:  rd_byte = val_r[15:8];
        PG_VAL2:  rd_byte = val_r[23:16];
        PG_VAL3:  rd_byte = val_r[31:24];
        PG_SHIFT: rd_byte = shcmd_r;
        PG_ROT:   rd_byte = rotcmd_r;
        PG_VER:   rd_byte = VER_BYTE;
        PG_SIG:   rd_byte = SIG_BYTE;
        default:  rd_byte = data_in;
      endcase
    end

    sel_ram  = data_acc && !func;
    imm_byte = func ? 8'h00 : rd_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        base_r[i] <= '0;
        off_r[i]  <= '0;
        inc_r[i]  <= '0;
        ctl_r[i]  <= '0;
      end
      val_r    <= '0;
      shcmd_r  <= '0;
      rotcmd_r <= '0;
    end else begin
      base_r   <= base_nxt;
      off_r    <= off_nxt;
      inc_r    <= inc_nxt;
      ctl_r    <= ctl_nxt;
      val_r    <= val_nxt;
      shcmd_r  <= shcmd_nxt;
      rotcmd_r <= rotcmd_nxt;
    end
  end

endmodule

// File: hdl/awin_fifo.sv
// ----------------------------------------------------------------------------
// awin_fifo
// Three-word result queue driving the result channel.
// ----------------------------------------------------------------------------
module awin_fifo
  import awin_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [7:0]   push_data,
  output logic [1:0]   count,
  awin_out_if.source   out_bus
);

  localparam logic [1:0] LAST = 2'd2;

  logic [7:0] mem [3];
  logic [1:0] wr_r, wr_nxt, rd_r, rd_nxt, cnt_r, cnt_nxt;
  logic       pop;

  always_comb begin
    pop     = out_bus.valid && out_bus.ready;
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    if (push) begin
      wr_nxt = (wr_r == LAST) ? 2'd0 : wr_r + 2'd1;
    end
    if (pop) begin
      rd_nxt = (rd_r == LAST) ? 2'd0 : rd_r + 2'd1;
    end
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

  assign out_bus.valid     = (cnt_r != 2'd0);
  assign out_bus.read_data = mem[rd_r];
  assign count             = cnt_r;

endmodule

// File: hdl/four_port_auto_increment_ram_window.sv
// ----------------------------------------------------------------------------
// four_port_auto_increment_ram_window
// An accepted word passes the RAM stage registers (stage flags and RAM read
// data) and is then written into the result queue, which offers it on out_bus.
// Throughput: one word per cycle while the input is not stalled, set by the single RAM access per cycle.
// Input stalls once the result queue and the RAM stage hold three words.
// Reset clears port, value and command registers; the RAM is not cleared.
// ----------------------------------------------------------------------------
`include "four_port_auto_increment_ram_window_defines.svh"

module four_port_auto_increment_ram_window
  import awin_pkg::*;
#(
  parameter int RAM_BYTES = 2097152
) (
  input  logic       clk,
  input  logic       rst_n,
  awin_in_if.sink    in_bus,
  awin_out_if.source out_bus
);

  awin_ram_req_t req;
  logic          in_acc, sel_ram;
  logic [7:0]    imm_byte, ram_q, push_data;
  logic [1:0]    fifo_cnt;
  logic          s1_valid_r, s1_sel_ram_r;
  logic [7:0]    s1_byte_r;

  assign in_bus.ready = ({1'b0, fifo_cnt} + {2'b00, s1_valid_r}) <= 3'd2;
  assign in_acc       = in_bus.valid && in_bus.ready;

  awin_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .func     (in_bus.func),
    .bank     (in_bus.bank),
    .address  (in_bus.address),
    .data_in  (in_bus.data_in),
    .req      (req),
    .sel_ram  (sel_ram),
    .imm_byte (imm_byte)
  );

  awin_ram #(.RAM_BYTES(RAM_BYTES)) u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sel_ram_r <= sel_ram;
      s1_byte_r    <= imm_byte;
    end
  end

  assign push_data = s1_sel_ram_r ? ram_q : s1_byte_r;

  awin_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .push_data (push_data),
    .count     (fifo_cnt),
    .out_bus   (out_bus)
  );

  `AWIN_ASSERT_NEXT(a_stage_follows_accept, in_acc, s1_valid_r)
  `AWIN_ASSERT_SAME(a_queue_full_no_push, fifo_cnt == 2'd3, !s1_valid_r)
  `AWIN_ASSERT_NEXT(a_ram_read_selected, in_acc && req.en && !req.we, s1_sel_ram_r)
  `AWIN_ASSERT_SAME(a_out_valid_count, out_bus.valid, fifo_cnt != 2'd0)

endmodule
